// ----- design/palette_run_sprite_decoder_assert.svh -----
// ---------------------------------------------------------------------------
// Palette run sprite decoder assertion macros
// Concurrent check macros, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef PALETTE_RUN_SPRITE_DECODER_ASSERT_SVH
`define PALETTE_RUN_SPRITE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PRSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PRSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define PRSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/prsd_pkg.sv -----
// ---------------------------------------------------------------------------
// Palette run sprite decoder package
// Shared types and constants of the sprite frame decoder.
// ---------------------------------------------------------------------------
package prsd_pkg;

    localparam int PAL_ENTRIES_DEF = 256;
    localparam int CUR_X_W = 13;

    localparam logic [31:0] END_WORD = 32'h7FFF_7FFF;
    localparam logic [9:0] MAX_DIM_RESET = 10'd800;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PALETTE = 3'd1,
        PH_SIZES   = 3'd2,
        PH_RUNWORD = 3'd3,
        PH_RUNPIX  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_BAD_SIZE = 2'd2
    } t_kind;

endpackage

// ----- design/palette_run_sprite_decoder.sv -----
// ---------------------------------------------------------------------------
// Palette run sprite decoder
// Parses a sprite frame byte stream (palette, header, pixel runs) and
// emits one pixel, frame-done or bad-size beat per byte at most.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------
//  input    | in        | i_valid / o_stall      | data_byte, frame_start, buffer_end
//  result   | out       | o_valid / i_stall      | kind, pixel_x, pixel_y, color
//  config   | in        | i_cfg_valid / o_cfg_ready | max_dimension
//
//  One byte per cycle while o_stall is low; the parse step and palette read
//  register each result in stage 1, then it moves to the output register and waits there.
//  Throughput is one byte a cycle while o_stall is low; the palette has one write and one read port.
//  Reset is synchronous; no clearing pass, the palette is rewritten per frame.
//  o_stall rises only while both result stages hold beats and i_stall is high.
// ---------------------------------------------------------------------------
`include "palette_run_sprite_decoder_assert.svh"

module palette_run_sprite_decoder #(
    parameter int PALETTE_ENTRIES = prsd_pkg::PAL_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [9:0]  o_pixel_x,
    output logic [9:0]  o_pixel_y,
    output logic [15:0] o_color,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);

    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W  = (PAL_AW + 1 > 3) ? PAL_AW + 1 : 3;
    localparam int XW     = prsd_pkg::CUR_X_W;

    logic [15:0] r_pal [PALETTE_ENTRIES];
    logic [15:0] r_rd;

    logic [9:0]  r_max;
    prsd_pkg::t_phase r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]  r_lo, n_lo;
    logic [15:0] r_cx, n_cx, r_cy, n_cy, r_w, n_w, r_h, n_h;
    logic [23:0] r_hdr, n_hdr;
    logic [11:0] r_run_left, n_run_left;
    logic [XW-1:0] r_cur_x, n_cur_x;
    logic [9:0]  r_cur_y, n_cur_y;
    logic        r_visible, n_visible;

    logic        r_s1_valid, r_s1_idx_ok;
    prsd_pkg::t_kind r_s1_kind;
    logic [9:0]  r_s1_x, r_s1_y;

    logic        r_out_valid;
    prsd_pkg::t_kind r_out_kind;
    logic [9:0]  r_out_x, r_out_y;
    logic [15:0] r_out_color;

    logic        acc, out_free, s1_adv, s1_free;
    logic        res_valid, res_idx_ok;
    prsd_pkg::t_kind res_kind;
    logic [9:0]  res_x, res_y;
    logic        wr_en;
    logic [PAL_AW-1:0] wr_addr;
    prsd_pkg::t_phase ph;
    logic [CNT_W-1:0] cnt;
    logic [31:0] word;
    logic [15:0] h_new;
    logic signed [16:0] run_x;
    logic signed [17:0] run_y;
    logic        w_ok, h_ok;
    logic        chk_full, chk_status, chk_clear, chk_bad, chk_idle, chk_end, chk_rest;

    assign out_free    = !r_out_valid || !i_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign s1_free     = !r_s1_valid || out_free;
    assign o_stall     = !s1_free;
    assign acc         = i_valid && s1_free;
    assign o_cfg_ready = 1'b1;

    assign ph    = i_frame_start ? prsd_pkg::PH_PALETTE : r_phase;
    assign cnt   = i_frame_start ? '0 : r_cnt;
    assign word  = {i_data_byte, r_hdr};
    assign h_new = {i_data_byte, r_h[7:0]};
    assign run_x = $signed({{7{word[31]}}, word[31:22]}) + $signed({r_cx[15], r_cx});
    assign run_y = $signed({{8{word[21]}}, word[21:12]}) + $signed({{2{r_cy[15]}}, r_cy})
                 + $signed({{2{r_h[15]}}, r_h});
    assign w_ok  = (r_w[15:10] == 6'd0) && (r_w[9:0] != 10'd0) && (r_w[9:0] <= r_max);
    assign h_ok  = (h_new[15:10] == 6'd0) && (h_new[9:0] != 10'd0) && (h_new[9:0] <= r_max);
    assign wr_addr = cnt[PAL_AW:1];

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_lo       = r_lo;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_w        = r_w;
        n_h        = r_h;
        n_hdr      = r_hdr;
        n_run_left = r_run_left;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_visible  = r_visible;
        res_valid  = 1'b0;
        res_kind   = prsd_pkg::KIND_DONE;
        res_x      = '0;
        res_y      = '0;
        res_idx_ok = 1'b0;
        wr_en      = 1'b0;
        if (acc && ph != prsd_pkg::PH_IDLE) begin
            n_phase = ph;
            n_cnt   = cnt + CNT_W'(1);
            case (ph)
                prsd_pkg::PH_PALETTE: begin
                    if (cnt[0]) begin
                        wr_en = 1'b1;
                    end else begin
                        n_lo = i_data_byte;
                    end
                    if (cnt == CNT_W'(2 * PALETTE_ENTRIES - 1)) begin
                        n_phase = prsd_pkg::PH_SIZES;
                        n_cnt   = '0;
                    end
                end
                prsd_pkg::PH_SIZES: begin
                    case (cnt[2:1])
                        2'd0: begin
                            if (cnt[0]) n_cx[15:8] = i_data_byte;
                            else        n_cx[7:0]  = i_data_byte;
                        end
                        2'd1: begin
                            if (cnt[0]) n_cy[15:8] = i_data_byte;
                            else        n_cy[7:0]  = i_data_byte;
                        end
                        2'd2: begin
                            if (cnt[0]) n_w[15:8] = i_data_byte;
                            else        n_w[7:0]  = i_data_byte;
                        end
                        default: begin
                            if (cnt[0]) n_h[15:8] = i_data_byte;
                            else        n_h[7:0]  = i_data_byte;
                        end
                    endcase
                    if (cnt == CNT_W'(7)) begin
                        n_cnt = '0;
                        if (w_ok && h_ok) begin
                            n_phase = prsd_pkg::PH_RUNWORD;
                        end else begin
                            n_phase   = prsd_pkg::PH_IDLE;
                            res_valid = 1'b1;
                            res_kind  = prsd_pkg::KIND_BAD_SIZE;
                        end
                    end
                end
                prsd_pkg::PH_RUNWORD: begin
                    case (cnt[1:0])
                        2'd0:    n_hdr[7:0]   = i_data_byte;
                        2'd1:    n_hdr[15:8]  = i_data_byte;
                        default: n_hdr[23:16] = i_data_byte;
                    endcase
                    if (cnt == CNT_W'(3)) begin
                        n_cnt = '0;
                        if (word == prsd_pkg::END_WORD) begin
                            n_phase   = prsd_pkg::PH_IDLE;
                            res_valid = 1'b1;
                            res_kind  = prsd_pkg::KIND_DONE;
                        end else begin
                            n_run_left = word[11:0];
                            n_visible  = !run_x[16] && !run_y[17]
                                       && (run_x[15:0] < r_w)
                                       && (run_y[16:0] < {1'b0, r_h});
                            n_cur_x    = run_x[XW-1:0];
                            n_cur_y    = run_y[9:0];
                            if (word[11:0] != 12'd0) begin
                                n_phase = prsd_pkg::PH_RUNPIX;
                            end
                        end
                    end
                end
                prsd_pkg::PH_RUNPIX: begin
                    n_cnt = r_cnt;
                    if (r_visible && ({{(16-XW){1'b0}}, r_cur_x} < r_w)) begin
                        res_valid  = 1'b1;
                        res_kind   = prsd_pkg::KIND_PIXEL;
                        res_x      = r_cur_x[9:0];
                        res_y      = r_cur_y;
                        res_idx_ok = ({1'b0, i_data_byte} < 9'(PALETTE_ENTRIES));
                    end
                    n_cur_x    = r_cur_x + XW'(1);
                    n_run_left = r_run_left - 12'd1;
                    if (r_run_left == 12'd1) begin
                        n_phase = prsd_pkg::PH_RUNWORD;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_phase = prsd_pkg::PH_IDLE;
                end
            endcase
            if (i_buffer_end) begin
                n_phase = prsd_pkg::PH_IDLE;
                n_cnt   = '0;
                if (!res_valid) begin
                    res_valid = 1'b1;
                    res_kind  = prsd_pkg::KIND_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pal[wr_addr] <= {i_data_byte, r_lo};
        end
        if (acc) begin
            r_rd <= r_pal[i_data_byte[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= prsd_pkg::MAX_DIM_RESET;
            r_phase <= prsd_pkg::PH_IDLE;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_w        <= n_w;
        r_h        <= n_h;
        r_hdr      <= n_hdr;
        r_run_left <= n_run_left;
        r_cur_x    <= n_cur_x;
        r_cur_y    <= n_cur_y;
        r_visible  <= n_visible;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc && res_valid) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && res_valid) begin
            r_s1_kind   <= res_kind;
            r_s1_x      <= res_x;
            r_s1_y      <= res_y;
            r_s1_idx_ok <= res_idx_ok;
        end
        if (s1_adv) begin
            r_out_kind  <= r_s1_kind;
            r_out_x     <= r_s1_x;
            r_out_y     <= r_s1_y;
            r_out_color <= r_s1_idx_ok ? r_rd : 16'd0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_kind    = r_out_kind;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_color   = r_out_color;

    assign chk_full   = r_s1_valid && r_out_valid;
    assign chk_status = o_valid && (o_kind != prsd_pkg::KIND_PIXEL);
    assign chk_clear  = (o_pixel_x == 10'd0) && (o_pixel_y == 10'd0) && (o_color == 16'd0);
    assign chk_bad    = acc && res_valid && (res_kind == prsd_pkg::KIND_BAD_SIZE);
    assign chk_idle   = (r_phase == prsd_pkg::PH_IDLE);
    assign chk_end    = acc && i_buffer_end;
    assign chk_rest   = chk_idle && (r_cnt == '0);

    `PRSD_ASSERT_SAME(a_stall_needs_full, i_clk, i_rst_n, o_stall, chk_full, "stall while free")
    `PRSD_ASSERT_SAME(a_status_zero, i_clk, i_rst_n, chk_status, chk_clear, "status not clear")
    `PRSD_ASSERT_NEXT(a_bad_size_idle, i_clk, i_rst_n, chk_bad, chk_idle, "busy after bad size")
    `PRSD_ASSERT_NEXT(a_end_idle, i_clk, i_rst_n, chk_end, chk_rest, "busy after buffer end")

endmodule
